// ===== rtl/core/radix_integer_to_text_defines.svh =====
// assertion macros for the radix conversion block
`ifndef RADIX_INTEGER_TO_TEXT_DEFINES_SVH
`define RADIX_INTEGER_TO_TEXT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RIT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define RIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rit_pkg.sv =====
`default_nettype none
package rit_pkg;

   localparam int MAX_BASE   = 16;
   localparam int MAX_DIGITS = 32;
   localparam int NUM_W      = 32;
   localparam int CHAR_W     = 8;
   localparam int CSR_W      = 64;
   localparam int DIGIT_W    = $clog2(MAX_BASE);
   localparam int RADIX_W    = $clog2(MAX_BASE + 1);
   localparam int SYM_W      = MAX_BASE * CHAR_W;
   localparam int NUM_BYTES  = NUM_W / CHAR_W;
   localparam int BYTE_IDX_W = $clog2(NUM_BYTES);
   localparam int STACK_IDX_W = $clog2(MAX_DIGITS);
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int CSR_IDX_W  = 2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0] RESET_BASE_LENGTH = RADIX_W'(10);
   localparam logic [CSR_W-1:0]   RESET_SYMBOLS_LOW  = 64'h3736353433323130;
   localparam logic [CSR_W-1:0]   RESET_SYMBOLS_HIGH = 64'h0000000000003938;

   typedef struct packed {
      logic               base_ok;
      logic [RADIX_W-1:0] radix;
      logic [SYM_W-1:0]   symbols;
   } cfg_type;

   typedef struct packed {
      logic             inval;
      logic             neg;
      logic [NUM_W-1:0] mag;
   } job_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] rem;
      logic [CHAR_W-1:0]  quo;
   } div_res_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SIGN  = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_INVAL = 5'b10000
   } state_type;

   // long division of one byte, remainder carried in from the byte above
   function automatic div_res_type div_byte(logic [DIGIT_W-1:0] rem,
                                            logic [CHAR_W-1:0] din,
                                            logic [RADIX_W-1:0] radix);
      logic [DIGIT_W:0]   r;
      logic [DIGIT_W-1:0] rr;
      logic [CHAR_W-1:0]  q;
      div_res_type        res;
      rr = rem;
      q  = '0;
      for (int i = CHAR_W - 1; i >= 0; i--) begin
         r = {rr, din[i]};
         if (r >= (DIGIT_W+1)'(radix)) begin
            r    = r - (DIGIT_W+1)'(radix);
            q[i] = 1'b1;
         end
         rr = r[DIGIT_W-1:0];
      end
      res.rem = rr;
      res.quo = q;
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rit_csr.sv =====
`default_nettype none
module rit_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rit_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rit_pkg::CSR_W-1:0]     csr_data,
   output rit_pkg::cfg_type                   cfg
);

   logic [rit_pkg::RADIX_W-1:0] base_len_ff, base_len_in;
   logic [rit_pkg::CSR_W-1:0]   sym_lo_ff, sym_lo_in;
   logic [rit_pkg::CSR_W-1:0]   sym_hi_ff, sym_hi_in;
   logic [rit_pkg::SYM_W-1:0]   syms;
   logic [rit_pkg::CHAR_W-1:0]  s;
   logic                        ok;

   assign csr_ready = 1'b1;

   always_comb begin
      base_len_in = base_len_ff;
      sym_lo_in   = sym_lo_ff;
      sym_hi_in   = sym_hi_ff;
      if (csr_valid) begin
         case (csr_index)
            rit_pkg::CSR_BASE_LENGTH:  base_len_in = csr_data[rit_pkg::RADIX_W-1:0];
            rit_pkg::CSR_SYMBOLS_LOW:  sym_lo_in   = csr_data;
            rit_pkg::CSR_SYMBOLS_HIGH: sym_hi_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff <= rit_pkg::RESET_BASE_LENGTH;
         sym_lo_ff   <= rit_pkg::RESET_SYMBOLS_LOW;
         sym_hi_ff   <= rit_pkg::RESET_SYMBOLS_HIGH;
      end else begin
         base_len_ff <= base_len_in;
         sym_lo_ff   <= sym_lo_in;
         sym_hi_ff   <= sym_hi_in;
      end
   end

   // base check: length range, forbidden symbols, repeats within the base
   always_comb begin
      syms = rit_pkg::SYM_W'({sym_hi_ff, sym_lo_ff});
      ok   = (base_len_ff >= rit_pkg::RADIX_W'(2)) &&
             (base_len_ff <= rit_pkg::RADIX_W'(rit_pkg::MAX_BASE));
      s    = '0;
      for (int a = 0; a < rit_pkg::MAX_BASE; a++) begin
         if (rit_pkg::RADIX_W'(a) < base_len_ff) begin
            s = syms[a*rit_pkg::CHAR_W +: rit_pkg::CHAR_W];
            if (s == '0 || s == rit_pkg::CHAR_PLUS || s == rit_pkg::CHAR_MINUS) begin
               ok = 1'b0;
            end
            for (int b = a + 1; b < rit_pkg::MAX_BASE; b++) begin
               if (rit_pkg::RADIX_W'(b) < base_len_ff &&
                   syms[b*rit_pkg::CHAR_W +: rit_pkg::CHAR_W] == s) begin
                  ok = 1'b0;
               end
            end
         end
      end
   end

   assign cfg.base_ok = ok;
   assign cfg.radix   = base_len_ff;
   assign cfg.symbols = syms;

endmodule
`default_nettype wire

// ===== rtl/core/rit_front.sv =====
`default_nettype none
module rit_front (
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [rit_pkg::NUM_W-1:0] req_tdata,
   input  wire logic                      base_ok,
   input  wire logic                      q_full,
   output logic                           push,
   output rit_pkg::job_type               job
);

   logic neg;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign neg        = req_tdata[rit_pkg::NUM_W-1];

   // negation wraps, so the most negative value keeps its magnitude
   assign job.inval = !base_ok;
   assign job.neg   = neg;
   assign job.mag   = neg ? (rit_pkg::NUM_W'(0) - req_tdata) : req_tdata;

endmodule
`default_nettype wire

// ===== rtl/core/rit_queue.sv =====
`default_nettype none
module rit_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  rit_pkg::job_type push_job,
   input  wire logic        pop,
   output rit_pkg::job_type head,
   output logic             empty,
   output logic             full
);

   rit_pkg::job_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/rit_back.sv =====
`default_nettype none
module rit_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  rit_pkg::cfg_type                cfg,
   input  rit_pkg::job_type                head,
   input  wire logic                       q_empty,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [rit_pkg::CHAR_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,
   output logic [0:0]                      rsp_tuser
);

   rit_pkg::state_type state_ff, state_in;
   logic [rit_pkg::NUM_W-1:0]       mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic [rit_pkg::BYTE_IDX_W-1:0]  byte_ff, byte_in;
   logic [rit_pkg::DIGIT_W-1:0]     rem_ff, rem_in;
   logic [rit_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [rit_pkg::DIGIT_W-1:0]     stack_ff [rit_pkg::MAX_DIGITS];
   logic                            out_valid_ff, out_valid_in;
   logic [rit_pkg::CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_inval_ff, out_inval_in;

   logic                              out_free;
   rit_pkg::div_res_type              dres;
   logic                              stack_we;
   logic [rit_pkg::STACK_IDX_W-1:0]   stack_wa;
   logic [rit_pkg::COUNT_W-1:0]       rd_pos;
   logic [rit_pkg::DIGIT_W-1:0]       rd_digit;

   assign out_free = !out_valid_ff || rsp_tready;
   assign dres     = rit_pkg::div_byte(rem_ff,
                        mag_ff[{byte_ff, 3'b000} +: rit_pkg::CHAR_W], cfg.radix);
   assign rd_pos   = count_ff - rit_pkg::COUNT_W'(1);
   assign rd_digit = stack_ff[rd_pos[rit_pkg::STACK_IDX_W-1:0]];
   assign stack_wa = count_ff[rit_pkg::STACK_IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      byte_in      = byte_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      pop          = 1'b0;
      stack_we     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_inval_in = out_inval_ff;
      case (state_ff)
         rit_pkg::ST_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               mag_in   = head.mag;
               neg_in   = head.neg;
               byte_in  = rit_pkg::BYTE_IDX_W'(rit_pkg::NUM_BYTES - 1);
               rem_in   = '0;
               count_in = '0;
               state_in = head.inval ? rit_pkg::ST_INVAL : rit_pkg::ST_DIV;
            end
         end
         rit_pkg::ST_DIV: begin
            mag_in[{byte_ff, 3'b000} +: rit_pkg::CHAR_W] = dres.quo;
            if (byte_ff == '0) begin
               stack_we = 1'b1;
               count_in = count_ff + rit_pkg::COUNT_W'(1);
               rem_in   = '0;
               byte_in  = rit_pkg::BYTE_IDX_W'(rit_pkg::NUM_BYTES - 1);
               if (mag_in == '0) begin
                  state_in = neg_ff ? rit_pkg::ST_SIGN : rit_pkg::ST_EMIT;
               end
            end else begin
               rem_in  = dres.rem;
               byte_in = byte_ff - rit_pkg::BYTE_IDX_W'(1);
            end
         end
         rit_pkg::ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = rit_pkg::CHAR_MINUS;
               out_last_in  = 1'b0;
               out_inval_in = 1'b0;
               state_in     = rit_pkg::ST_EMIT;
            end
         end
         rit_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = cfg.symbols[{rd_digit, 3'b000} +: rit_pkg::CHAR_W];
               out_last_in  = (count_ff == rit_pkg::COUNT_W'(1));
               out_inval_in = 1'b0;
               count_in     = rd_pos;
               if (count_ff == rit_pkg::COUNT_W'(1)) begin
                  state_in = rit_pkg::ST_IDLE;
               end
            end
         end
         rit_pkg::ST_INVAL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = '0;
               out_last_in  = 1'b1;
               out_inval_in = 1'b1;
               state_in     = rit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rit_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      byte_ff      <= byte_in;
      rem_ff       <= rem_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_inval_ff <= out_inval_in;
      if (stack_we) begin
         stack_ff[stack_wa] <= dres.rem;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_inval_ff;

endmodule
`default_nettype wire

// ===== rtl/core/radix_integer_to_text.sv =====
// Converts each signed 32-bit number on the req stream into its text in the
// configured radix (2 to 16), most significant digit first, with a leading
// minus sign for negative numbers; the most negative value converts
// correctly. Each digit value d is sent as symbol byte d of the table held
// in the symbols_low and symbols_high registers. If the base fails its check
// (length outside 2 to 16, a zero, plus or minus symbol, or a repeated
// symbol) the number gives a single beat with character zero, tlast and the
// invalid flag in tuser. Timing: a shared divide unit takes one byte of the
// magnitude per cycle, so each digit takes one pass over its four bytes;
// then each character leaves at one per cycle while rsp_tready is high.
// A two-entry queue between the input side and the converter takes new
// numbers while one is in progress. Registers should be written only
// while the block is idle.
`default_nettype none
module radix_integer_to_text (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [rit_pkg::NUM_W-1:0]     req_tdata,  // [31:0] number
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [rit_pkg::CHAR_W-1:0]         rsp_tdata,  // [7:0] character
   output logic                               rsp_tlast,
   output logic [0:0]                         rsp_tuser,  // [0] base_invalid
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rit_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rit_pkg::CSR_W-1:0]     csr_data
);

   rit_pkg::cfg_type cfg;
   rit_pkg::job_type push_job;
   rit_pkg::job_type head;
   logic             push;
   logic             pop;
   logic             q_empty;
   logic             q_full;

   rit_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rit_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .base_ok    (cfg.base_ok),
      .q_full     (q_full),
      .push       (push),
      .job        (push_job)
   );

   rit_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   rit_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== rtl/core/rit_checker.sv =====
`default_nettype none
`include "radix_integer_to_text_defines.svh"
module rit_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [rit_pkg::CHAR_W-1:0]    rsp_tdata,
   input wire logic                          rsp_tlast,
   input wire logic [0:0]                    rsp_tuser,
   input wire logic                          csr_valid,
   input wire logic                          csr_ready
);

   // stalled result beat holds
   `RIT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser),
      "result beat changed while stalled")

   // invalid-base beat is a lone zero beat
   `RIT_ASSERT_NOW(a_inval_beat, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == '0 && rsp_tlast, "invalid-base beat malformed")

   // a sign beat is always followed by digits
   `RIT_ASSERT_NOW(a_sign_not_last, clock, reset,
      rsp_tvalid && !rsp_tuser[0] && rsp_tdata == rit_pkg::CHAR_MINUS,
      !rsp_tlast, "minus sign marked as last")

   // register writes are never refused
   `RIT_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready, "register write stalled")

endmodule

bind radix_integer_to_text rit_checker u_checker (.*);
`default_nettype wire
